// ----- hw/rtl/tdi_pkg.sv -----
// ----------------------------------------------------------------------------
// tdi_pkg
// Shared widths, codes and helpers of the tabulated dispersion interpolator.
// ----------------------------------------------------------------------------
package tdi_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int GRID_DEPTH   = 1024;
	localparam int BUCKET_DEPTH = 1024;
	localparam int GAW          = $clog2(GRID_DEPTH);
	localparam int BAW          = $clog2(BUCKET_DEPTH);

	localparam int VAL_W  = 32;
	localparam int K_W    = 31;
	localparam int STEP_W = 31;
	localparam int IDX_W  = 10;
	localparam int TGT_W  = 10;
	localparam int LAST_W = 10;

	// unsigned divider: DIV_Q_W quotient bits, one per stage
	localparam int DIV_Q_W    = 32;
	localparam int DIV_DVD_W  = DIV_Q_W + FRAC_BITS;
	localparam int DIV_STAGES = DIV_Q_W;

	localparam int S_TDATA_W  = 120;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 64;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REQ_GRID   = 2'd0;
	localparam logic [1:0] REQ_BUCKET = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_GRID   = 2'd1;
	localparam logic [1:0] STAT_BUCKET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MU   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST = 2'd2;

	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
		if (v > SAT_HI)
			return SAT_HI[VAL_W-1:0];
		else if (v < SAT_LO)
			return SAT_LO[VAL_W-1:0];
		else
			return v[VAL_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/tdi_ram.sv -----
// ----------------------------------------------------------------------------
// tdi_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tdi_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/tdi_div.sv -----
// ----------------------------------------------------------------------------
// tdi_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module tdi_div import tdi_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_DVD_W-1:0] dvd,
	input  logic [DIV_Q_W-1:0]   dvs,
	output logic [DIV_Q_W-1:0]   quo,
	output logic                 ovf
);

	logic [DIV_Q_W-1:0] rem_q [DIV_STAGES];
	logic [DIV_Q_W-1:0] dq_q  [DIV_STAGES];
	logic [DIV_Q_W-1:0] dvs_q [DIV_STAGES];
	logic               ovf_q [DIV_STAGES];

	logic [DIV_Q_W-1:0] rem_in [DIV_STAGES];
	logic [DIV_Q_W-1:0] dq_in  [DIV_STAGES];
	logic [DIV_Q_W-1:0] dvs_in [DIV_STAGES];
	logic               ovf_in [DIV_STAGES];

	always_comb begin
		rem_in[0] = DIV_Q_W'(dvd[DIV_DVD_W-1:DIV_Q_W]);
		dq_in[0]  = dvd[DIV_Q_W-1:0];
		dvs_in[0] = dvs;
		// high part not below the divisor: quotient needs more bits
		ovf_in[0] = DIV_Q_W'(dvd[DIV_DVD_W-1:DIV_Q_W]) >= dvs;
		for (int i = 1; i < DIV_STAGES; i++) begin
			rem_in[i] = rem_q[i-1];
			dq_in[i]  = dq_q[i-1];
			dvs_in[i] = dvs_q[i-1];
			ovf_in[i] = ovf_q[i-1];
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [DIV_Q_W:0] trial;
		logic             ge;

		assign trial = {rem_in[i], dq_in[i][DIV_Q_W-1]};
		assign ge    = trial >= {1'b0, dvs_in[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? DIV_Q_W'(trial - {1'b0, dvs_in[i]}) : trial[DIV_Q_W-1:0];
				dq_q[i]  <= {dq_in[i][DIV_Q_W-2:0], ge};
				dvs_q[i] <= dvs_in[i];
				ovf_q[i] <= ovf_in[i];
			end
		end
	end

	assign quo = dq_q[DIV_STAGES-1];
	assign ovf = ovf_q[DIV_STAGES-1];

endmodule

// ----- hw/rtl/tabulated_dispersion_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// tabulated_dispersion_interpolator_top
// Grid and bucket tables with three-point Lagrange interpolation of sigma.
// ----------------------------------------------------------------------------
// Pipeline: two 32-stage dividers, bucket map read, grid read, three
//   multiply/sum stages, output register, from input word to result word.
// Throughput: one word per cycle; the whole pipeline holds while a result
//   word waits on m_tready.
// Reset: clears pipeline valids and loads register defaults; the tables are
//   not cleared and hold garbage until written.
module tabulated_dispersion_interpolator_top import tdi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// table_index, grid_momentum, grid_sigma, bucket_target, query_momentum
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [S_TUSER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// energy, sigma_value
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [M_TUSER_W-1:0]  m_tuser
);

	typedef struct packed {
		logic             vld;
		logic [1:0]       req;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] mom;
		logic [VAL_W-1:0] sig;
		logic [TGT_W-1:0] tgt;
		logic [K_W-1:0]   k;
	} front_t;

	typedef struct packed {
		front_t     f;
		logic [1:0] st;
	} bstage_t;

	typedef struct packed {
		logic           vld;
		logic           calc;
		logic [1:0]     st;
		logic [K_W-1:0] k;
	} gstage_t;

	typedef struct packed {
		logic                  vld;
		logic                  calc;
		logic [1:0]            st;
		logic [K_W-1:0]        k;
		logic [2:0][VAL_W-1:0] fv;
		logic [5:0]            neg;
		logic [5:0]            zero;
	} mid_t;

	typedef struct packed {
		logic                  vld;
		logic                  calc;
		logic [1:0]            st;
		logic [2*K_W-1:0]      kk;
		logic [2:0][VAL_W-1:0] fv;
		logic [2:0][63:0]      prod;
	} m1_t;

	typedef struct packed {
		logic             vld;
		logic             calc;
		logic [1:0]       st;
		logic [2*K_W-1:0] kk;
		logic [2:0][63:0] pf;
	} m2_t;

	typedef struct packed {
		logic             vld;
		logic             calc;
		logic [1:0]       st;
		logic [2*K_W-1:0] kk;
		logic [VAL_W-1:0] sigma;
	} m3_t;

	typedef struct packed {
		logic             vld;
		logic [1:0]       st;
		logic [VAL_W-1:0] energy;
		logic [VAL_W-1:0] sigma;
	} out_t;

	logic [STEP_W-1:0]       step_q;
	logic signed [VAL_W-1:0] mu_q;
	logic [LAST_W-1:0]       last_q;

	logic    adv;
	front_t  fin;
	front_t  pa_q [DIV_STAGES];
	bstage_t b_q;
	gstage_t g_q;
	mid_t    mid;
	mid_t    pb_q [DIV_STAGES];
	m1_t     m1_s1;
	m2_t     m2_s2;
	m3_t     m3_s3;
	out_t    out_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(65536);
			mu_q   <= '0;
			last_q <= LAST_W'(1023);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP: step_q <= cfg_data[STEP_W-1:0];
				CFG_MU:   mu_q   <= cfg_data[VAL_W-1:0];
				CFG_LAST: last_q <= cfg_data[LAST_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_q.vld || m_tready;
	assign s_tready = adv;

	always_comb begin
		fin.vld = s_tvalid;
		fin.req = s_tuser;
		fin.idx = s_tdata[9:0];
		fin.mom = s_tdata[41:10];
		fin.sig = s_tdata[73:42];
		fin.tgt = s_tdata[83:74];
		fin.k   = s_tdata[114:84];
	end

	// ---------------- bucket divide ----------------
	logic [DIV_Q_W-1:0] qa;
	logic               ovfa;

	tdi_div u_bdiv (
		.clk (clk),
		.en  (adv),
		.dvd (DIV_DVD_W'(fin.k)),
		.dvs (DIV_Q_W'(step_q)),
		.quo (qa),
		.ovf (ovfa)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				pa_q[i] <= '0;
		end else if (adv) begin
			pa_q[0] <= fin;
			for (int i = 1; i < DIV_STAGES; i++)
				pa_q[i] <= pa_q[i-1];
		end
	end

	// ---------------- bucket map access ----------------
	front_t           fa;
	logic             bucket_bad;
	logic             bmap_we;
	logic [TGT_W-1:0] bmap_rd;

	assign fa         = pa_q[DIV_STAGES-1];
	assign bucket_bad = (step_q == '0) || ovfa || (qa >= DIV_Q_W'(BUCKET_DEPTH));
	assign bmap_we    = adv && fa.vld && (fa.req == REQ_BUCKET)
		&& (32'(fa.idx) < BUCKET_DEPTH);

	tdi_ram #(.W(TGT_W), .DEPTH(BUCKET_DEPTH)) u_bmap (
		.clk   (clk),
		.we    (bmap_we),
		.waddr (BAW'(fa.idx)),
		.wdata (fa.tgt),
		.re    (adv),
		.raddr (qa[BAW-1:0]),
		.rdata (bmap_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (adv) begin
			b_q.f  <= fa;
			b_q.st <= (fa.req == REQ_QUERY && bucket_bad) ? STAT_BUCKET : STAT_OK;
		end
	end

	// ---------------- grid access ----------------
	logic [31:0]          last_w;
	logic [31:0]          cen_w;
	logic [31:0]          i1_w;
	logic                 cen_bad;
	logic [1:0]           st_b;
	logic                 grid_we;
	logic [GAW-1:0]       gaddr [3];
	logic [2*VAL_W-1:0]   grd   [3];

	always_comb begin
		last_w = 32'(last_q);
		if (last_w < 32'd2)
			last_w = 32'd2;
		if (last_w > 32'(GRID_DEPTH - 1))
			last_w = 32'(GRID_DEPTH - 1);
		cen_w   = 32'(bmap_rd);
		cen_bad = cen_w > last_w;
		// clamp the triple at both ends
		if (cen_w == '0)
			i1_w = '0;
		else if (cen_w == last_w)
			i1_w = last_w - 32'd2;
		else
			i1_w = cen_w - 32'd1;
		gaddr[0] = GAW'(i1_w);
		gaddr[1] = GAW'(i1_w + 32'd1);
		gaddr[2] = GAW'(i1_w + 32'd2);
		st_b = b_q.st;
		if (b_q.f.req == REQ_QUERY && b_q.st == STAT_OK && cen_bad)
			st_b = STAT_GRID;
	end

	assign grid_we = adv && b_q.f.vld && (b_q.f.req == REQ_GRID)
		&& (32'(b_q.f.idx) < GRID_DEPTH);

	for (genvar c = 0; c < 3; c++) begin : g_grid
		tdi_ram #(.W(2*VAL_W), .DEPTH(GRID_DEPTH)) u_grid (
			.clk   (clk),
			.we    (grid_we),
			.waddr (GAW'(b_q.f.idx)),
			.wdata ({b_q.f.mom, b_q.f.sig}),
			.re    (adv),
			.raddr (gaddr[c]),
			.rdata (grd[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= '0;
		end else if (adv) begin
			g_q.vld  <= b_q.f.vld;
			g_q.calc <= b_q.f.vld && (b_q.f.req == REQ_QUERY) && (st_b == STAT_OK);
			g_q.st   <= st_b;
			g_q.k    <= b_q.f.k;
		end
	end

	// ---------------- ratio dividers ----------------
	logic signed [32:0]   ks;
	logic signed [32:0]   pm [3];
	logic signed [32:0]   nk [3];
	logic signed [32:0]   nn [6];
	logic signed [32:0]   dd [6];
	logic [DIV_DVD_W-1:0] rdvd [6];
	logic [DIV_Q_W-1:0]   rdvs [6];
	logic [DIV_Q_W-1:0]   rq   [6];
	logic                 rovf [6];

	always_comb begin
		ks = $signed({2'b00, g_q.k});
		for (int c = 0; c < 3; c++) begin
			pm[c] = 33'($signed(grd[c][2*VAL_W-1:VAL_W]));
			nk[c] = ks - pm[c];
		end
		nn[0] = nk[1]; dd[0] = pm[0] - pm[1];
		nn[1] = nk[2]; dd[1] = pm[0] - pm[2];
		nn[2] = nk[0]; dd[2] = pm[1] - pm[0];
		nn[3] = nk[2]; dd[3] = pm[1] - pm[2];
		nn[4] = nk[0]; dd[4] = pm[2] - pm[0];
		nn[5] = nk[1]; dd[5] = pm[2] - pm[1];
		mid.vld  = g_q.vld;
		mid.calc = g_q.calc;
		mid.st   = g_q.st;
		mid.k    = g_q.k;
		for (int c = 0; c < 3; c++)
			mid.fv[c] = grd[c][VAL_W-1:0];
		for (int j = 0; j < 6; j++) begin
			mid.neg[j]  = nn[j][32] ^ dd[j][32];
			mid.zero[j] = (dd[j] == '0);
			rdvd[j] = {(nn[j][32] ? 32'(-nn[j]) : nn[j][31:0]), FRAC_BITS'(0)};
			rdvs[j] = dd[j][32] ? 32'(-dd[j]) : dd[j][31:0];
		end
	end

	for (genvar j = 0; j < 6; j++) begin : g_rdiv
		tdi_div u_rdiv (
			.clk (clk),
			.en  (adv),
			.dvd (rdvd[j]),
			.dvs (rdvs[j]),
			.quo (rq[j]),
			.ovf (rovf[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				pb_q[i] <= '0;
		end else if (adv) begin
			pb_q[0] <= mid;
			for (int i = 1; i < DIV_STAGES; i++)
				pb_q[i] <= pb_q[i-1];
		end
	end

	// ---------------- weights and interpolation ----------------
	mid_t                    fb;
	logic signed [VAL_W-1:0] rs [6];

	assign fb = pb_q[DIV_STAGES-1];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			// truncate toward zero, saturate to the signed word
			if (fb.zero[j])
				rs[j] = '0;
			else if (!fb.neg[j])
				rs[j] = (rovf[j] || rq[j][31]) ? SAT_HI[VAL_W-1:0] : rq[j];
			else
				rs[j] = (rovf[j] || rq[j] > 32'h8000_0000) ? SAT_LO[VAL_W-1:0]
					: 32'(-rq[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_s1 <= '0;
		end else if (adv) begin
			m1_s1.vld     <= fb.vld;
			m1_s1.calc    <= fb.calc;
			m1_s1.st      <= fb.st;
			m1_s1.fv      <= fb.fv;
			m1_s1.kk      <= fb.k * fb.k;
			m1_s1.prod[0] <= 64'(rs[0]) * 64'(rs[1]);
			m1_s1.prod[1] <= 64'(rs[2]) * 64'(rs[3]);
			m1_s1.prod[2] <= 64'(rs[4]) * 64'(rs[5]);
		end
	end

	logic signed [VAL_W-1:0] wt [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			wt[c] = sat_val($signed(m1_s1.prod[c]) >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m2_s2 <= '0;
		end else if (adv) begin
			m2_s2.vld  <= m1_s1.vld;
			m2_s2.calc <= m1_s1.calc;
			m2_s2.st   <= m1_s1.st;
			m2_s2.kk   <= m1_s1.kk;
			for (int c = 0; c < 3; c++)
				m2_s2.pf[c] <= 64'($signed(m1_s1.fv[c])) * 64'(wt[c]);
		end
	end

	logic signed [63:0] sig_sum;

	assign sig_sum = ($signed(m2_s2.pf[0]) >>> FRAC_BITS)
		+ ($signed(m2_s2.pf[1]) >>> FRAC_BITS)
		+ ($signed(m2_s2.pf[2]) >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m3_s3 <= '0;
		end else if (adv) begin
			m3_s3.vld   <= m2_s2.vld;
			m3_s3.calc  <= m2_s2.calc;
			m3_s3.st    <= m2_s2.st;
			m3_s3.kk    <= m2_s2.kk;
			m3_s3.sigma <= sat_val(sig_sum);
		end
	end

	// ---------------- energy and output register ----------------
	logic signed [63:0]      e_sum;
	logic signed [VAL_W-1:0] e_sat;

	assign e_sum = ($signed({2'b00, m3_s3.kk}) >>> FRAC_BITS)
		+ 64'($signed(m3_s3.sigma)) - 64'(mu_q);
	assign e_sat = sat_val(e_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (adv) begin
			out_q.vld    <= m3_s3.vld;
			out_q.st     <= m3_s3.st;
			out_q.energy <= m3_s3.calc ? e_sat : '0;
			out_q.sigma  <= m3_s3.calc ? m3_s3.sigma : '0;
		end
	end

	assign m_tvalid = out_q.vld;
	assign m_tdata  = {out_q.sigma, out_q.energy};
	assign m_tuser  = out_q.st;

endmodule
